@@ src/prwh_pkg.sv @@
// ----------------------------------------------------------------------------
// prwh_pkg
// Shared types and constants of the horizontal Prewitt RGB filter.
// ----------------------------------------------------------------------------
package prwh_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // one window column, top row first
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    pixel_t pix;
    logic   frame_end;
  } out_beat_t;

  typedef enum logic [1:0] {
    SRC_FILT = 2'd0,
    SRC_UP   = 2'd1,
    SRC_MID  = 2'd2
  } src_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  localparam int unsigned WIDTH_RESET  = 640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // x / 3 == (x * 683) >> 11 for x < 768
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  localparam int FIFO_DEPTH = 3;

endpackage

@@ src/prwh_line_ram.sv @@
// ----------------------------------------------------------------------------
// prwh_line_ram
// Line buffer: one write port, two registered read ports, write-to-read
// forwarding when a read hits the address written on the same edge.
// ----------------------------------------------------------------------------
module prwh_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ src/prwh_out_fifo.sv @@
// ----------------------------------------------------------------------------
// prwh_out_fifo
// Small result queue between the filter stage and the output channel.
// ----------------------------------------------------------------------------
module prwh_out_fifo (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push_i,
  input  prwh_pkg::out_beat_t                      push_data_i,
  input  logic                                     pop_ready_i,
  output logic                                     valid_o,
  output prwh_pkg::out_beat_t                      data_o,
  output logic [$clog2(prwh_pkg::FIFO_DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(prwh_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(prwh_pkg::FIFO_DEPTH + 1);

  prwh_pkg::out_beat_t entry_q [prwh_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(prwh_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(prwh_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/prewitt_horizontal_rgb_filter.sv @@
// ----------------------------------------------------------------------------
// prewitt_horizontal_rgb_filter
// A result beat is registered in the filter stage, then queued. One beat per
// cycle while the result queue has room; line buffer reads and the window
// update sit between the input register stage and a 3-entry result queue.
// Reset: counters, held count and window clear; width 640, height 480; line
// buffers are not cleared. A register write also clears counters and window.
// ----------------------------------------------------------------------------
module prewitt_horizontal_rgb_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        frame_end_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int FCW   = $clog2(prwh_pkg::FIFO_DEPTH + 1);
  localparam int W_RST = (prwh_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                             : prwh_pkg::WIDTH_RESET;

  function automatic logic [7:0] grad_chan(input logic [7:0] r0, input logic [7:0] r1,
                                           input logic [7:0] r2, input logic [7:0] l0,
                                           input logic [7:0] l1, input logic [7:0] l2);
    logic [9:0]  rs;
    logic [9:0]  ls;
    logic [9:0]  d;
    logic [18:0] p;
    rs = 10'(r0) + 10'(r1) + 10'(r2);
    ls = 10'(l0) + 10'(l1) + 10'(l2);
    d  = (rs >= ls) ? rs - ls : ls - rs;
    p  = 19'(d) * 19'(prwh_pkg::DIV3_MUL);
    return p[prwh_pkg::DIV3_SHIFT +: 8];
  endfunction

  // configuration
  logic [WW-1:0]  width_q, width_d;
  logic [15:0]    height_q, height_d;
  logic [10:0]    wr_width;
  logic [WW-1:0]  w_m1;
  logic [15:0]    h_m1;
  logic [PW-1:0]  w_p1;

  // positions and held count
  logic [CW-1:0]  in_col_q, in_col_d;
  logic [15:0]    in_row_q, in_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [15:0]    out_row_q, out_row_d;
  logic [PW-1:0]  pend_q, pend_d;

  logic           acc;
  logic           pend_full;
  logic           interior;
  logic           fe_now;
  logic           out_step;

  // filter stage
  logic           a_wr_q, a_wr_d;
  logic           a_res_q, a_res_d;
  prwh_pkg::src_e a_src_q, a_src_d;
  logic           a_fe_q;
  prwh_pkg::pixel_t a_px_q;
  logic [CW-1:0]  a_ic_q;

  prwh_pkg::column_t win1_q, win1_d;
  prwh_pkg::column_t win2_q, win2_d;
  prwh_pkg::column_t new_col;

  prwh_pkg::pixel_t up_ic, up_oc, mid_ic, mid_oc;
  prwh_pkg::pixel_t filt;
  prwh_pkg::out_beat_t res_beat;
  prwh_pkg::out_beat_t head;
  logic [FCW-1:0] fifo_cnt;
  logic [FCW:0]   credit;

  assign wr_width = cfg_data_i[10:0];
  assign w_m1     = width_q - WW'(1);
  assign h_m1     = height_q - 16'd1;
  assign w_p1     = PW'(width_q) + PW'(1);

  assign credit     = (FCW + 1)'(fifo_cnt) + (FCW + 1)'(a_res_q);
  assign in_ready_o = (credit < (FCW + 1)'(prwh_pkg::FIFO_DEPTH));
  assign acc        = in_valid_i && in_ready_o;

  assign pend_full = (pend_q == w_p1);
  assign interior  = (out_row_q != 16'd0) && (out_row_q < h_m1)
                   && (out_col_q != '0) && (WW'(out_col_q) < w_m1);
  assign fe_now    = (out_row_q == h_m1) && (WW'(out_col_q) == w_m1);

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    a_wr_d    = 1'b0;
    a_res_d   = 1'b0;
    a_src_d   = prwh_pkg::SRC_UP;
    out_step  = 1'b0;
    win1_d    = win1_q;
    win2_d    = win2_q;

    if (a_wr_q) begin
      win1_d = win2_q;
      win2_d = new_col;
    end

    if (cfg_we_i) begin
      unique case (prwh_pkg::cfg_idx_e'(cfg_idx_i))
        prwh_pkg::CFG_WIDTH: begin
          if (wr_width == '0) begin
            width_d = WW'(1);
          end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(wr_width);
          end
        end
        prwh_pkg::CFG_HEIGHT: begin
          height_d = (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
        end
        default: begin
          width_d = width_q;
        end
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = '0;
      win1_d    = '0;
      win2_d    = '0;
    end else if (acc) begin
      unique case (prwh_pkg::mode_e'(mode_i))
        prwh_pkg::MODE_PIXEL: begin
          a_wr_d = 1'b1;
          if (WW'(in_col_q) == w_m1) begin
            in_col_d = '0;
            in_row_d = (in_row_q == h_m1) ? 16'd0 : in_row_q + 16'd1;
          end else begin
            in_col_d = in_col_q + CW'(1);
          end
          if (pend_full) begin
            a_res_d  = 1'b1;
            a_src_d  = interior ? prwh_pkg::SRC_FILT : prwh_pkg::SRC_UP;
            out_step = 1'b1;
          end else begin
            pend_d = pend_q + PW'(1);
          end
        end
        prwh_pkg::MODE_FLUSH: begin
          if (pend_q != '0) begin
            a_res_d  = 1'b1;
            a_src_d  = pend_full ? prwh_pkg::SRC_UP : prwh_pkg::SRC_MID;
            out_step = 1'b1;
            pend_d   = pend_q - PW'(1);
          end
        end
        default: begin
          a_wr_d = 1'b0;
        end
      endcase
      if (out_step) begin
        if (WW'(out_col_q) == w_m1) begin
          out_col_d = '0;
          out_row_d = (out_row_q == h_m1) ? 16'd0 : out_row_q + 16'd1;
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WW'(W_RST);
      height_q  <= prwh_pkg::HEIGHT_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
      a_wr_q    <= 1'b0;
      a_res_q   <= 1'b0;
      win1_q    <= '0;
      win2_q    <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
      a_wr_q    <= a_wr_d;
      a_res_q   <= a_res_d;
      win1_q    <= win1_d;
      win2_q    <= win2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_src_q <= a_src_d;
      a_fe_q  <= fe_now;
      a_px_q  <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
      a_ic_q  <= in_col_q;
    end
  end

  prwh_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(prwh_pkg::pixel_t))
  ) u_upper (
    .clk_i     (clk_i),
    .we_i      (a_wr_q),
    .waddr_i   (a_ic_q),
    .wdata_i   (mid_ic),
    .re_i      (acc),
    .raddr_a_i (in_col_q),
    .raddr_b_i (out_col_q),
    .rdata_a_o (up_ic),
    .rdata_b_o (up_oc)
  );

  prwh_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(prwh_pkg::pixel_t))
  ) u_middle (
    .clk_i     (clk_i),
    .we_i      (a_wr_q),
    .waddr_i   (a_ic_q),
    .wdata_i   (a_px_q),
    .re_i      (acc),
    .raddr_a_i (in_col_q),
    .raddr_b_i (out_col_q),
    .rdata_a_o (mid_ic),
    .rdata_b_o (mid_oc)
  );

  assign new_col = '{top: up_ic, mid: mid_ic, bot: a_px_q};

  // right column is the incoming one, left column is the older window column
  assign filt.red   = grad_chan(new_col.top.red, new_col.mid.red, new_col.bot.red,
                                win1_q.top.red, win1_q.mid.red, win1_q.bot.red);
  assign filt.green = grad_chan(new_col.top.green, new_col.mid.green, new_col.bot.green,
                                win1_q.top.green, win1_q.mid.green, win1_q.bot.green);
  assign filt.blue  = grad_chan(new_col.top.blue, new_col.mid.blue, new_col.bot.blue,
                                win1_q.top.blue, win1_q.mid.blue, win1_q.bot.blue);

  always_comb begin
    res_beat.frame_end = a_fe_q;
    unique case (a_src_q)
      prwh_pkg::SRC_FILT: res_beat.pix = filt;
      prwh_pkg::SRC_UP:   res_beat.pix = up_oc;
      prwh_pkg::SRC_MID:  res_beat.pix = mid_oc;
      default:            res_beat.pix = up_oc;
    endcase
  end

  prwh_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (a_res_q),
    .push_data_i (res_beat),
    .pop_ready_i (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (fifo_cnt)
  );

  assign red_out_o   = head.pix.red;
  assign green_out_o = head.pix.green;
  assign blue_out_o  = head.pix.blue;
  assign frame_end_o = head.frame_end;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the horizontal Prewitt RGB filter. Pixel and flush
// beats are pushed with random gaps and random output stalls, results are
// predicted per accepted beat and compared in order. Phases cover reset
// config, a run at the width cap that writes every line entry the narrow
// frames touch, a directed 3x3 frame with full-scale gradients, and random
// frames and noise under random width and height settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_W      = 1024;
  localparam int GAP_MAX    = 19;
  localparam int WDOG_LIMIT = 1000;
  localparam int RAND_ITEMS = 400;

  typedef struct packed {
    prwh_pkg::mode_e  mode;
    prwh_pkg::pixel_t px;
  } px_item_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [0:0]  cfg_idx  = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  px_item_t    drv_item = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_fe;

  always #10 clk_i = ~clk_i;

  prewitt_horizontal_rgb_filter #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .mode_i     (drv_item.mode),
    .red_in_i   (drv_item.px.red),
    .green_in_i (drv_item.px.green),
    .blue_in_i  (drv_item.px.blue),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .red_out_o  (out_red),
    .green_out_o(out_green),
    .blue_out_o (out_blue),
    .frame_end_o(out_fe)
  );

  // stream predictor state
  prwh_pkg::pixel_t  up_line [MAX_W];
  prwh_pkg::pixel_t  mid_line [MAX_W];
  prwh_pkg::column_t win [3];
  int unsigned in_col, in_row, out_col, out_row, held;
  logic [10:0] reg_w;
  logic [15:0] reg_h;

  px_item_t            feed_q [$];
  prwh_pkg::out_beat_t due_beats [$];

  int unsigned n_fed, n_acc, n_checked, n_fe, n_wr, n_err;
  int unsigned in_gap, out_stall, stall_draw, quiet;
  bit in_acc, out_acc, in_calm, out_calm;

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic prwh_pkg::pixel_t rand_px();
    prwh_pkg::pixel_t p;
    p.red   = rand_chan();
    p.green = rand_chan();
    p.blue  = rand_chan();
    return p;
  endfunction

  function automatic int unsigned eff_w();
    if (reg_w == 0) return 1;
    if (reg_w > MAX_W) return MAX_W;
    return reg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_h == 0) ? 1 : reg_h;
  endfunction

  function automatic void clear_run();
    foreach (win[k]) win[k] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    held = 0;
  endfunction

  function automatic void adv(inout int unsigned col, inout int unsigned row,
                              input int unsigned w, input int unsigned h);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function automatic logic [7:0] grad3(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2,
                                       logic [7:0] l0, logic [7:0] l1, logic [7:0] l2);
    int rs;
    int ls;
    rs = int'(r0) + int'(r1) + int'(r2);
    ls = int'(l0) + int'(l1) + int'(l2);
    return (rs >= ls) ? 8'((rs - ls) / 3) : 8'((ls - rs) / 3);
  endfunction

  // advance the stream by one accepted beat, queue the result it releases
  function automatic void track_pixel_stream(prwh_pkg::mode_e mode, prwh_pkg::pixel_t px);
    int unsigned         w, h, ic;
    bit                  emit, interior;
    prwh_pkg::pixel_t    thru, val;
    prwh_pkg::out_beat_t ob;
    w = eff_w();
    h = eff_h();
    if (in_col >= w || in_row >= h) begin
      in_col = 0;
      in_row = 0;
    end
    if (out_col >= w || out_row >= h) begin
      out_col = 0;
      out_row = 0;
    end
    if (held > w + 1) held = w + 1;
    if (mode == prwh_pkg::MODE_PIXEL) begin
      emit = held >= w + 1;
      interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
      thru = up_line[out_col];
      ic = in_col;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = '{top: up_line[ic], mid: mid_line[ic], bot: px};
      up_line[ic] = mid_line[ic];
      mid_line[ic] = px;
      adv(in_col, in_row, w, h);
      if (!emit) begin
        held++;
        return;
      end
      if (interior) begin
        val.red   = grad3(win[2].top.red, win[2].mid.red, win[2].bot.red,
                          win[0].top.red, win[0].mid.red, win[0].bot.red);
        val.green = grad3(win[2].top.green, win[2].mid.green, win[2].bot.green,
                          win[0].top.green, win[0].mid.green, win[0].bot.green);
        val.blue  = grad3(win[2].top.blue, win[2].mid.blue, win[2].bot.blue,
                          win[0].top.blue, win[0].mid.blue, win[0].bot.blue);
      end else begin
        val = thru;
      end
    end else begin
      if (held == 0) return;
      val = (held >= w + 1) ? up_line[out_col] : mid_line[out_col];
      held--;
    end
    ob.pix = val;
    ob.frame_end = (out_row == h - 1) && (out_col == w - 1);
    adv(out_col, out_row, w, h);
    due_beats.push_back(ob);
  endfunction

  task automatic report(string what, logic [23:0] want, logic [23:0] got);
    n_err++;
    if (n_err <= 20)
      $display("mismatch on result beat %0d: %s expected %0h got %0h", n_checked, what, want,
               got);
  endtask

  task automatic check_beat();
    prwh_pkg::out_beat_t exp_b;
    if (due_beats.size() == 0) begin
      report("unexpected beat", '0, {out_red, out_green, out_blue});
      return;
    end
    exp_b = due_beats.pop_front();
    if (out_red !== exp_b.pix.red) report("red", exp_b.pix.red, out_red);
    if (out_green !== exp_b.pix.green) report("green", exp_b.pix.green, out_green);
    if (out_blue !== exp_b.pix.blue) report("blue", exp_b.pix.blue, out_blue);
    if (out_fe !== exp_b.frame_end) report("frame_end", exp_b.frame_end, out_fe);
    n_checked++;
    if (out_fe === 1'b1) n_fe++;
  endtask

  // sample handshakes; predict on input beats, check output beats
  always @(posedge clk_i) begin
    in_acc <= in_valid && in_ready;
    out_acc <= out_valid && out_ready;
    if (rst_ni && in_valid && in_ready) begin
      track_pixel_stream(drv_item.mode, drv_item.px);
      n_acc++;
    end
    if (rst_ni && out_valid && out_ready) check_beat();
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding", quiet,
               due_beats.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (feed_q.size() > 0) begin
        drv_item <= feed_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall generator
  always @(negedge clk_i) begin
    if (out_acc) begin
      stall_draw = draw_wait(out_calm);
      if (stall_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_stall <= stall_draw - 1;
      end
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic add_item(prwh_pkg::mode_e mode, prwh_pkg::pixel_t px);
    feed_q.push_back('{mode: mode, px: px});
    n_fed++;
  endtask

  task automatic wait_idle(int unsigned settle);
    while (feed_q.size() != 0 || in_valid || due_beats.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(prwh_pkg::cfg_idx_e idx, logic [15:0] data);
    wait_idle(8);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == prwh_pkg::CFG_WIDTH) begin
      reg_w = data[10:0];
    end else begin
      reg_h = data;
    end
    clear_run();
    n_wr++;
  endtask

  function automatic logic [15:0] pick_width();
    logic [10:0] w;
    w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 3)) : 11'($urandom_range(1, 24));
    return {5'($urandom), w};
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic rand_phase();
    int unsigned w, h, n;
    if ($urandom_range(0, 9) < 7) write_reg(prwh_pkg::CFG_WIDTH, pick_width());
    if ($urandom_range(0, 9) < 7) write_reg(prwh_pkg::CFG_HEIGHT, pick_height());
    w = eff_w();
    h = eff_h();
    if ($urandom_range(0, 9) < 7) begin
      // one or two whole frames (a shorter run above 300 beats), mostly drained by flush ticks
      n = w * h * $urandom_range(1, 2);
      if (n > 300) n = $urandom_range(w + 1, 300);
      repeat (n) add_item(prwh_pkg::MODE_PIXEL, rand_px());
      if ($urandom_range(0, 4) != 0)
        repeat (w + 1 + $urandom_range(0, 2)) add_item(prwh_pkg::MODE_FLUSH, rand_px());
    end else begin
      n = $urandom_range(5, 60);
      repeat (n) add_item(prwh_pkg::mode_e'($urandom_range(0, 3) == 0), rand_px());
    end
  endtask

  initial begin : stim
    int unsigned base;
    int k;
    reg_w = 11'(prwh_pkg::WIDTH_RESET);
    reg_h = prwh_pkg::HEIGHT_RESET;
    clear_run();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: flush on empty, a few pixels, drain them
    add_item(prwh_pkg::MODE_FLUSH, rand_px());
    add_item(prwh_pkg::MODE_PIXEL, '0);
    add_item(prwh_pkg::MODE_PIXEL, '1);
    add_item(prwh_pkg::MODE_PIXEL, 24'hA55AC3);
    add_item(prwh_pkg::MODE_PIXEL, 24'h5AA53C);
    repeat (5) add_item(prwh_pkg::MODE_FLUSH, rand_px());

    // width above the cap, one row and a bit: every entry the narrow frames
    // below can touch holds a pixel in both line buffers
    write_reg(prwh_pkg::CFG_WIDTH, 16'hFFFF);
    write_reg(prwh_pkg::CFG_HEIGHT, 16'd3);
    repeat (MAX_W + 32) add_item(prwh_pkg::MODE_PIXEL, rand_px());

    // 3x3 frame, full-scale gradient in both directions on the center pixel
    write_reg(prwh_pkg::CFG_WIDTH, 16'd3);
    write_reg(prwh_pkg::CFG_HEIGHT, 16'd3);
    for (k = 0; k < 9; k++) begin
      case (k % 3)
        0: add_item(prwh_pkg::MODE_PIXEL, 24'hFF0080);
        1: add_item(prwh_pkg::MODE_PIXEL, rand_px());
        default: add_item(prwh_pkg::MODE_PIXEL, 24'h00FF7F);
      endcase
    end
    repeat (4) add_item(prwh_pkg::MODE_FLUSH, rand_px());

    base = n_fed;
    while (n_fed < base + RAND_ITEMS) rand_phase();

    wait_idle(24);
    $display("run covered %0d input beats, %0d result beats (%0d frame ends), %0d reg writes",
             n_acc, n_checked, n_fe, n_wr);
    $display("widths 1 to capped max, heights 1 to 65535, mid-frame and end-of-frame flushes");
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
